/* rtl/pxx_pkg.sv */
package pxx_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int PW_W         = 12;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 8;
    localparam int PC_W         = 5;
    localparam int REP_W        = 3;
    localparam int SCALE_W      = 11;
    localparam int RECIP_W      = 22;
    localparam int PROD_W       = SCALE_W + RECIP_W;

    localparam logic [PW_W-1:0]    PULSE_MIN    = 12'd817;
    localparam logic [PW_W-1:0]    PULSE_SAT    = 12'd2182;
    localparam logic [RECIP_W-1:0] SCALE_RECIP  = 22'd3146497;
    localparam int                 SCALE_SHIFT  = 21;
    localparam logic [SCALE_W-1:0] SCALE_LOW    = 11'd1;
    localparam logic [SCALE_W-1:0] SCALE_HIGH   = 11'd2047;
    localparam logic [15:0]        CRC_MUL      = 16'h1081;

    localparam logic [BYTE_W-1:0] RECEIVER_RESET = 8'd16;
    localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'd0;
    localparam logic [BYTE_W-1:0] EXTRAS_RESET   = 8'(1 << 2);

    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG1    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG2    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRAS   = 8'd3;

    // Coded symbol lengths: the last serial bit of a symbol is a one.
    localparam logic [1:0] LEN_FLUSH = 2'd1;
    localparam logic [1:0] LEN_ZERO  = 2'd2;
    localparam logic [1:0] LEN_ONE   = 2'd3;

    localparam logic [15:0] CRC_NIB [16] = '{
        16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
        16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
    };

    typedef enum logic [2:0] {
        OP_JUMP,
        OP_START,
        OP_CODED,
        OP_DATA,
        OP_MUL,
        OP_CHAN,
        OP_FLUSH,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        COND_SLOT_NZ,
        COND_SLOT_EVEN,
        COND_NOT_LAST
    } cond_t;

    typedef enum logic [3:0] {
        SRC_RX,
        SRC_FLAG1,
        SRC_FLAG2,
        SRC_CH0,
        SRC_CH1,
        SRC_CH2,
        SRC_EXTRAS,
        SRC_CRC_HI,
        SRC_CRC_LO
    } src_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             value;
        logic [REP_W-1:0] count;
        src_t             src;
    } uword_t;

    typedef struct packed {
        logic [BYTE_W-1:0] receiver;
        logic [BYTE_W-1:0] flag1;
        logic [BYTE_W-1:0] flag2;
        logic [BYTE_W-1:0] extras;
    } cfg_t;

    typedef struct packed {
        logic       issue;
        logic [1:0] len;
        logic       tail;
    } ser_cmd_t;

    typedef struct packed {
        logic free;
        logic idle;
        logic shift_nz;
        logic stall;
    } ser_stat_t;

    localparam logic [PC_W-1:0] L_SCALE   = 5'd9;
    localparam logic [PC_W-1:0] L_TRAILER = 5'd15;
    localparam logic [PC_W-1:0] L_END     = 5'd23;

    function automatic uword_t mk(op_t op, cond_t cond, logic [PC_W-1:0] target,
                                  logic value, logic [REP_W-1:0] count, src_t src);
        uword_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.value  = value;
        w.count  = count;
        w.src    = src;
        return w;
    endfunction

    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            5'd0:    w = mk(OP_JUMP,  COND_SLOT_NZ,   L_SCALE, 1'b0, 3'd1, SRC_RX);
            5'd1:    w = mk(OP_START, COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd2:    w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b0, 3'd4, SRC_RX);
            5'd3:    w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd4:    w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b1, 3'd6, SRC_RX);
            5'd5:    w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd6:    w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd7:    w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_FLAG1);
            5'd8:    w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_FLAG2);
            5'd9:    w = mk(OP_MUL,   COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd10:   w = mk(OP_CHAN,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd11:   w = mk(OP_JUMP,  COND_SLOT_EVEN, L_TRAILER, 1'b0, 3'd1, SRC_RX);
            5'd12:   w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_CH0);
            5'd13:   w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_CH1);
            5'd14:   w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_CH2);
            5'd15:   w = mk(OP_JUMP,  COND_NOT_LAST,  L_END,   1'b0, 3'd1, SRC_RX);
            5'd16:   w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_EXTRAS);
            5'd17:   w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_CRC_HI);
            5'd18:   w = mk(OP_DATA,  COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_CRC_LO);
            5'd19:   w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd20:   w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b1, 3'd6, SRC_RX);
            5'd21:   w = mk(OP_CODED, COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            5'd22:   w = mk(OP_FLUSH, COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
            default: w = mk(OP_END,   COND_SLOT_NZ,   '0,      1'b0, 3'd1, SRC_RX);
        endcase
        return w;
    endfunction

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] v;
        logic [15:0]       t;
        v = crc[15:8] ^ d;
        t = CRC_NIB[v[3:0]] ^ 16'(CRC_MUL * 16'(v[7:4]));
        return {crc[7:0], 8'h00} ^ t;
    endfunction

endpackage

/* rtl/pxx_if.sv */
interface pxx_in_if;
    logic                        valid;
    logic                        ready;
    logic [pxx_pkg::PW_W-1:0]    pulse_width;
    logic                        upper_bank;

    modport source (output valid, output pulse_width, output upper_bank, input ready);
    modport sink   (input valid, input pulse_width, input upper_bank, output ready);
endinterface

interface pxx_out_if;
    logic                        valid;
    logic                        ready;
    logic [pxx_pkg::BYTE_W-1:0]  serial_byte;
    logic                        frame_end;

    modport source (output valid, output serial_byte, output frame_end, input ready);
    modport sink   (input valid, input serial_byte, input frame_end, output ready);
endinterface

interface pxx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pxx_pkg::CFG_IDX_W-1:0] index;
    logic [pxx_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pxx_ser.sv */
module pxx_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  pxx_pkg::ser_cmd_t   cmd,
    output pxx_pkg::ser_stat_t  stat,
    pxx_out_if.source           serial
);
    import pxx_pkg::*;

    logic [1:0]        cp_len_reg, cp_len_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [2:0]        count_reg, count_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_end_reg, out_end_next;
    logic              out_valid_reg, out_valid_next;

    logic emit;
    logic sbit;
    logic done;
    logic stall;

    assign emit  = cp_len_reg != 2'd0;
    assign sbit  = cp_len_reg == LEN_FLUSH;
    assign done  = emit && (count_reg == 3'd7);
    assign stall = done && out_valid_reg && !serial.ready;

    assign stat.free     = cp_len_reg <= LEN_FLUSH;
    assign stat.idle     = !emit;
    assign stat.shift_nz = count_reg != 3'd0;
    assign stat.stall    = stall;

    assign serial.valid       = out_valid_reg;
    assign serial.serial_byte = out_byte_reg;
    assign serial.frame_end   = out_end_reg;

    always_comb
    begin
        cp_len_next    = cp_len_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg;
        if (!stall)
        begin
            if (out_valid_reg && serial.ready)
            begin
                out_valid_next = 1'b0;
            end
            if (emit)
            begin
                shift_next = {sbit, shift_reg[BYTE_W-1:1]};
                count_next = count_reg + 3'd1;
            end
            if (done)
            begin
                out_byte_next  = {sbit, shift_reg[BYTE_W-1:1]};
                out_end_next   = cmd.tail && sbit;
                out_valid_next = 1'b1;
            end
            if (cmd.issue)
            begin
                cp_len_next = cmd.len;
            end
            else if (emit)
            begin
                cp_len_next = cp_len_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_len_reg    <= '0;
            shift_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cp_len_reg    <= cp_len_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

endmodule

/* rtl/pxx_seq.sv */
module pxx_seq #(
    parameter int CHANNELS_PER_FRAME = pxx_pkg::CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    pxx_in_if.sink              pulses,
    input  pxx_pkg::cfg_t       cfg,
    input  pxx_pkg::ser_stat_t  stat,
    output pxx_pkg::ser_cmd_t   cmd
);
    import pxx_pkg::*;

    localparam int                SLOT_W    = $clog2(CHANNELS_PER_FRAME);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHANNELS_PER_FRAME - 1);

    logic               busy_reg, busy_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [REP_W-1:0]   rep_reg, rep_next;
    logic [3:0]         bitc_reg, bitc_next;
    logic               stuff_reg, stuff_next;
    logic [BYTE_W-1:0]  dbyte_reg, dbyte_next;
    logic [BYTE_W-1:0]  snap_reg, snap_next;
    logic [PW_W-1:0]    w_reg, w_next;
    logic               bank_in_reg, bank_in_next;
    logic [SCALE_W-1:0] q_reg, q_next;
    logic [PW_W-1:0]    chan_reg, chan_next;
    logic [PW_W-1:0]    held_reg, held_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               bank_reg, bank_next;
    logic [15:0]        crc_reg, crc_next;
    logic [2:0]         ones_reg, ones_next;

    uword_t             cw;
    logic               accept;
    logic               last_slot;
    logic               cond_true;
    logic [BYTE_W-1:0]  src_byte;
    logic               data_bit;
    logic [SCALE_W-1:0] t_diff;
    logic [PROD_W-1:0]  product;
    logic [SCALE_W-1:0] scaled;
    logic [PW_W-1:0]    chan;

    assign cw        = ucode(pc_reg);
    assign pulses.ready = !busy_reg;
    assign accept    = pulses.valid && !busy_reg;
    assign last_slot = slot_reg == LAST_SLOT;
    assign data_bit  = (bitc_reg == 4'd0) ? src_byte[BYTE_W-1] : dbyte_reg[BYTE_W-1];

    assign t_diff  = SCALE_W'(w_reg - PULSE_MIN);
    assign product = PROD_W'(t_diff) * PROD_W'(SCALE_RECIP);

    always_comb
    begin
        if (w_reg <= PULSE_MIN)
        begin
            scaled = SCALE_LOW;
        end
        else if (w_reg >= PULSE_SAT)
        begin
            scaled = SCALE_HIGH;
        end
        else
        begin
            scaled = q_reg;
        end
        chan = {bank_reg, scaled};
    end

    always_comb
    begin
        unique case (cw.src)
            SRC_RX:     src_byte = cfg.receiver;
            SRC_FLAG1:  src_byte = cfg.flag1;
            SRC_FLAG2:  src_byte = cfg.flag2;
            SRC_CH0:    src_byte = held_reg[7:0];
            SRC_CH1:    src_byte = {chan_reg[3:0], held_reg[11:8]};
            SRC_CH2:    src_byte = chan_reg[11:4];
            SRC_EXTRAS: src_byte = cfg.extras;
            SRC_CRC_HI: src_byte = crc_reg[15:8];
            SRC_CRC_LO: src_byte = snap_reg;
            default:    src_byte = cfg.receiver;
        endcase
    end

    always_comb
    begin
        unique case (cw.cond)
            COND_SLOT_NZ:   cond_true = slot_reg != '0;
            COND_SLOT_EVEN: cond_true = !slot_reg[0];
            COND_NOT_LAST:  cond_true = !last_slot;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        rep_next     = rep_reg;
        bitc_next    = bitc_reg;
        stuff_next   = stuff_reg;
        dbyte_next   = dbyte_reg;
        snap_next    = snap_reg;
        w_next       = w_reg;
        bank_in_next = bank_in_reg;
        q_next       = q_reg;
        chan_next    = chan_reg;
        held_next    = held_reg;
        slot_next    = slot_reg;
        bank_next    = bank_reg;
        crc_next     = crc_reg;
        ones_next    = ones_reg;
        cmd.issue    = 1'b0;
        cmd.len      = LEN_ZERO;
        cmd.tail     = busy_reg && (cw.op == OP_FLUSH);

        if (accept)
        begin
            busy_next    = 1'b1;
            pc_next      = '0;
            w_next       = pulses.pulse_width;
            bank_in_next = pulses.upper_bank;
        end
        else if (busy_reg && !stat.stall)
        begin
            unique case (cw.op)
                OP_JUMP:
                begin
                    pc_next = cond_true ? cw.target : pc_reg + 1'b1;
                end
                OP_START:
                begin
                    bank_next = bank_in_reg;
                    crc_next  = '0;
                    ones_next = '0;
                    pc_next   = pc_reg + 1'b1;
                end
                OP_CODED:
                begin
                    if (stat.free)
                    begin
                        cmd.issue = 1'b1;
                        cmd.len   = cw.value ? LEN_ONE : LEN_ZERO;
                        if (rep_reg == cw.count - 1'b1)
                        begin
                            rep_next = '0;
                            pc_next  = pc_reg + 1'b1;
                        end
                        else
                        begin
                            rep_next = rep_reg + 1'b1;
                        end
                    end
                end
                OP_DATA:
                begin
                    if (stat.free)
                    begin
                        cmd.issue = 1'b1;
                        if (stuff_reg)
                        begin
                            cmd.len    = LEN_ZERO;
                            stuff_next = 1'b0;
                            if (bitc_reg == 4'd8)
                            begin
                                bitc_next = '0;
                                pc_next   = pc_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.len = data_bit ? LEN_ONE : LEN_ZERO;
                            if (bitc_reg == 4'd0)
                            begin
                                dbyte_next = {src_byte[BYTE_W-2:0], 1'b0};
                                crc_next   = crc_step(crc_reg, src_byte);
                                if (cw.src == SRC_CRC_HI)
                                begin
                                    snap_next = crc_reg[7:0];
                                end
                            end
                            else
                            begin
                                dbyte_next = {dbyte_reg[BYTE_W-2:0], 1'b0};
                            end
                            if (data_bit && (ones_reg == 3'd4))
                            begin
                                ones_next  = '0;
                                stuff_next = 1'b1;
                                bitc_next  = bitc_reg + 4'd1;
                            end
                            else
                            begin
                                ones_next = data_bit ? ones_reg + 3'd1 : 3'd0;
                                if (bitc_reg == 4'd7)
                                begin
                                    bitc_next = '0;
                                    pc_next   = pc_reg + 1'b1;
                                end
                                else
                                begin
                                    bitc_next = bitc_reg + 4'd1;
                                end
                            end
                        end
                    end
                end
                OP_MUL:
                begin
                    q_next  = product[SCALE_SHIFT +: SCALE_W];
                    pc_next = pc_reg + 1'b1;
                end
                OP_CHAN:
                begin
                    chan_next = chan;
                    if (!slot_reg[0])
                    begin
                        held_next = chan;
                    end
                    pc_next = pc_reg + 1'b1;
                end
                OP_FLUSH:
                begin
                    if (stat.idle)
                    begin
                        if (stat.shift_nz)
                        begin
                            cmd.issue = 1'b1;
                            cmd.len   = LEN_FLUSH;
                        end
                        else
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                end
                OP_END:
                begin
                    if (stat.idle)
                    begin
                        busy_next = 1'b0;
                        slot_next = last_slot ? '0 : slot_reg + 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pc_reg    <= '0;
            rep_reg   <= '0;
            bitc_reg  <= '0;
            stuff_reg <= 1'b0;
            held_reg  <= '0;
            slot_reg  <= '0;
            bank_reg  <= 1'b0;
            crc_reg   <= '0;
            ones_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            rep_reg   <= rep_next;
            bitc_reg  <= bitc_next;
            stuff_reg <= stuff_next;
            held_reg  <= held_next;
            slot_reg  <= slot_next;
            bank_reg  <= bank_next;
            crc_reg   <= crc_next;
            ones_reg  <= ones_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dbyte_reg   <= dbyte_next;
        snap_reg    <= snap_next;
        w_reg       <= w_next;
        bank_in_reg <= bank_in_next;
        q_reg       <= q_next;
        chan_reg    <= chan_next;
    end

endmodule

/* rtl/pxx_frame_encoder.sv */
// An item's run time grows with the coded serial bits it produces and with its flush bits.
// An item that completes a channel pair sends the pair's bytes, and the last item of a frame
// adds the trailer, CRC, sync and flush. The serial coder emits one serial bit per clock
// while the output word is taken; a new item is taken once the previous microprogram ends.
// Reset (rst_n low, asynchronous) clears the control state and loads the register defaults.
module pxx_frame_encoder #(
    parameter int CHANNELS_PER_FRAME = pxx_pkg::CHANNELS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pxx_in_if.sink    pulses,
    pxx_out_if.source serial,
    pxx_cfg_if.sink   cfg
);
    import pxx_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    ser_cmd_t  cmd;
    ser_stat_t stat;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RECEIVER: cfg_next.receiver = cfg.data;
                REG_FLAG1:    cfg_next.flag1    = cfg.data;
                REG_FLAG2:    cfg_next.flag2    = cfg.data;
                REG_EXTRAS:   cfg_next.extras   = cfg.data;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.receiver <= RECEIVER_RESET;
            cfg_reg.flag1    <= FLAG_RESET;
            cfg_reg.flag2    <= FLAG_RESET;
            cfg_reg.extras   <= EXTRAS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pxx_seq #(
        .CHANNELS_PER_FRAME(CHANNELS_PER_FRAME)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .pulses (pulses),
        .cfg    (cfg_reg),
        .stat   (stat),
        .cmd    (cmd)
    );

    pxx_ser u_ser (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .serial (serial)
    );

endmodule

/* rtl/pxx_frame_encoder_chk.sv */
module pxx_frame_encoder_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pxx_pkg::BYTE_W-1:0] serial_byte,
    input logic                       frame_end
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word dropped while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(serial_byte) && $stable(frame_end))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("encoder did not go busy after taking a word");

    a_no_output_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |=> !$rose(out_valid))
        else $error("output word appeared while the encoder was idle");

endmodule

bind pxx_frame_encoder pxx_frame_encoder_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pulses.valid),
    .in_ready    (pulses.ready),
    .out_valid   (serial.valid),
    .out_ready   (serial.ready),
    .serial_byte (serial.serial_byte),
    .frame_end   (serial.frame_end)
);
